// ===== hdl/tlam_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile layout address map package
// Beat types, opcodes, register indexes and size clamps shared by the block.
// ----------------------------------------------------------------------------
package tlam_pkg;

    localparam int CFG_DW = 11;

    localparam logic [4:0]  MAX_MICRO  = 5'd16;
    localparam logic [10:0] MAX_DIM    = 11'd1024;
    localparam logic [1:0]  CFG_SETTLE = 2'd3;

    localparam logic [1:0] OP_FWD  = 2'd0;
    localparam logic [1:0] OP_INV  = 2'd1;
    localparam logic [1:0] OP_FLAT = 2'd2;

    typedef enum logic [2:0] {
        CFG_MICRO_ROWS,
        CFG_MICRO_COLS,
        CFG_MACRO_ROWS,
        CFG_MACRO_COLS,
        CFG_COLUMN_FIRST,
        CFG_TENSOR_SLICES,
        CFG_TENSOR_ROWS,
        CFG_TENSOR_COLS
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  slice_in;
        logic [9:0]  row_in;
        logic [9:0]  col_in;
        logic [9:0]  grid_row_in;
        logic [9:0]  grid_col_in;
        logic [23:0] address_in;
        logic [29:0] flat_index;
    } tlam_in_t;

    typedef struct packed {
        logic [23:0] slice_out;
        logic [19:0] row_out;
        logic [19:0] col_out;
        logic [9:0]  grid_row_out;
        logic [9:0]  grid_col_out;
        logic [23:0] address_out;
        logic        range_error;
    } tlam_out_t;

    function automatic logic [4:0] clamp_micro(input logic [4:0] v);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (v > MAX_MICRO) begin
            r = MAX_MICRO;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [10:0] clamp_dim(input logic [10:0] v);
        logic [10:0] r;
        if (v == 11'd0) begin
            r = 11'd1;
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/tlam_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, DW stages; divisor and side payload travel
// with each beat. All stages advance together on en.
// ----------------------------------------------------------------------------
module tlam_div #(
    parameter int DW = 30,
    parameter int VW = 29,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_num,
    input  logic [VW-1:0] in_den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [DW-1:0] out_quo,
    output logic [VW-1:0] out_rem,
    output logic [PW-1:0] out_pay
);

    logic [VW-1:0] rem_reg  [DW];
    logic [VW-1:0] rem_next [DW];
    logic [DW-1:0] nq_reg   [DW];
    logic [DW-1:0] nq_next  [DW];
    logic [VW-1:0] den_reg  [DW];
    logic [VW-1:0] den_next [DW];
    logic [PW-1:0] pay_reg  [DW];
    logic [PW-1:0] pay_next [DW];
    logic [DW-1:0] vld_reg;
    logic [DW-1:0] vld_next;

    logic [VW-1:0] src_rem;
    logic [VW-1:0] src_den;
    logic [DW-1:0] src_nq;
    logic [PW-1:0] src_pay;
    logic          src_vld;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    always_comb begin
        for (int k = 0; k < DW; k++) begin
            if (k == 0) begin
                src_rem = '0;
                src_nq  = in_num;
                src_den = in_den;
                src_pay = in_pay;
                src_vld = in_valid;
            end else begin
                src_rem = rem_reg[(k == 0) ? 0 : k - 1];
                src_nq  = nq_reg[(k == 0) ? 0 : k - 1];
                src_den = den_reg[(k == 0) ? 0 : k - 1];
                src_pay = pay_reg[(k == 0) ? 0 : k - 1];
                src_vld = vld_reg[(k == 0) ? 0 : k - 1];
            end
            trial       = {src_rem, src_nq[DW-1]};
            ge          = (trial >= {1'b0, src_den});
            diff        = trial - {1'b0, src_den};
            rem_next[k] = ge ? diff[VW-1:0] : trial[VW-1:0];
            nq_next[k]  = {src_nq[DW-2:0], ge};
            den_next[k] = src_den;
            pay_next[k] = src_pay;
            vld_next[k] = src_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DW; k++) begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= den_next[k];
                pay_reg[k] <= pay_next[k];
            end
        end
    end

    assign out_valid = vld_reg[DW-1];
    assign out_quo   = nq_reg[DW-1];
    assign out_rem   = rem_reg[DW-1];
    assign out_pay   = pay_reg[DW-1];

endmodule

// ===== hdl/tile_layout_address_map_unit.sv =====
// ----------------------------------------------------------------------------
// Tile layout address map unit
// Canonical <-> core grid / linear address translation for blocked tensors.
// ----------------------------------------------------------------------------
// Takes one beat per clock while s_ready is high and returns one result beat
// per input beat, in order. A beat passes 88 register stages, counting the
// one that takes it: six bit-per-stage dividers chained in four levels
// (30, 24, 20 and 10 stages), then three stages of multiply and add, then
// the output register. After reset and after each configuration write,
// s_ready stays low while settle_reg counts down and the derived block
// sizes settle. A skid entry behind the output register takes one more
// beat while a result waits on m_ready. When both are full, the whole
// pipeline and s_ready hold until m_ready frees a slot.
module tile_layout_address_map_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tlam_pkg::tlam_in_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tlam_pkg::tlam_out_t          m_data,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_addr,
    input  logic [tlam_pkg::CFG_DW-1:0]  cfg_wr_data
);

    import tlam_pkg::*;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] slice_in;
        logic [9:0] row_in;
        logic [9:0] col_in;
        logic [9:0] grid_row_in;
        logic [9:0] grid_col_in;
    } d1_pay_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [29:0] tq;
        logic [9:0]  row_in;
        logic [9:0]  col_in;
        logic [9:0]  grid_row_in;
        logic [9:0]  grid_col_in;
    } d2_pay_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        err;
        logic [23:0] tq;
        logic [9:0]  grid_row_in;
    } d3_pay_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        err;
        logic [23:0] tq;
        logic [9:0]  grid_row_in;
        logic [9:0]  grid_col_in;
        logic [9:0]  wq;
        logic [9:0]  wr;
        logic [7:0]  uq;
    } d5_pay_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        err;
        logic [9:0]  gr;
        logic [9:0]  gc;
        logic [23:0] tq;
        logic [23:0] fp1;
        logic [23:0] fp2;
        logic [18:0] fp3;
        logic [9:0]  fp4;
        logic [19:0] ip1;
        logic [15:0] ip2;
        logic [19:0] ip3;
        logic [15:0] ip4;
    } e1_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        err;
        logic [9:0]  gr;
        logic [9:0]  gc;
        logic [23:0] tq;
        logic [23:0] lin_a;
        logic [19:0] lin_b;
        logic [19:0] row;
        logic [19:0] col;
    } e2_t;

    // configuration
    logic [4:0]  micro_rows_reg;
    logic [4:0]  micro_cols_reg;
    logic [10:0] macro_rows_reg;
    logic [10:0] macro_cols_reg;
    logic        column_first_reg;
    logic [10:0] tensor_slices_reg;
    logic [10:0] tensor_rows_reg;
    logic [10:0] tensor_cols_reg;
    logic [1:0]  settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            micro_rows_reg    <= 5'd1;
            micro_cols_reg    <= 5'd1;
            macro_rows_reg    <= 11'd1;
            macro_cols_reg    <= 11'd1;
            column_first_reg  <= 1'b0;
            tensor_slices_reg <= 11'd1;
            tensor_rows_reg   <= 11'd1;
            tensor_cols_reg   <= 11'd1;
            settle_reg        <= CFG_SETTLE;
        end else begin
            if (cfg_wr_en) begin
                settle_reg <= CFG_SETTLE;
                unique case (cfg_addr)
                    CFG_MICRO_ROWS:    micro_rows_reg    <= cfg_wr_data[4:0];
                    CFG_MICRO_COLS:    micro_cols_reg    <= cfg_wr_data[4:0];
                    CFG_MACRO_ROWS:    macro_rows_reg    <= cfg_wr_data;
                    CFG_MACRO_COLS:    macro_cols_reg    <= cfg_wr_data;
                    CFG_COLUMN_FIRST:  column_first_reg  <= cfg_wr_data[0];
                    CFG_TENSOR_SLICES: tensor_slices_reg <= cfg_wr_data;
                    CFG_TENSOR_ROWS:   tensor_rows_reg   <= cfg_wr_data;
                    CFG_TENSOR_COLS:   tensor_cols_reg   <= cfg_wr_data;
                    default: ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // derived block sizes, three register levels
    logic [4:0]  ur_reg, uc_reg;
    logic [10:0] mm_reg, mn_reg, ts_reg, tr_reg, tc_reg;
    logic        cf_reg;
    logic [8:0]  uvol_reg;
    logic [20:0] mmmn_reg, plane_reg;
    logic [14:0] mmur_reg, mnuc_reg;
    logic [10:0] mmn_reg;
    logic [28:0] mvol_reg;
    logic [18:0] kstride_reg;

    always_ff @(posedge aclk) begin
        ur_reg      <= clamp_micro(micro_rows_reg);
        uc_reg      <= clamp_micro(micro_cols_reg);
        mm_reg      <= clamp_dim(macro_rows_reg);
        mn_reg      <= clamp_dim(macro_cols_reg);
        ts_reg      <= clamp_dim(tensor_slices_reg);
        tr_reg      <= clamp_dim(tensor_rows_reg);
        tc_reg      <= clamp_dim(tensor_cols_reg);
        cf_reg      <= column_first_reg;
        uvol_reg    <= 9'(ur_reg) * 9'(uc_reg);
        mmmn_reg    <= 21'(mm_reg) * 21'(mn_reg);
        plane_reg   <= 21'(tr_reg) * 21'(tc_reg);
        mmur_reg    <= 15'(mm_reg) * 15'(ur_reg);
        mnuc_reg    <= 15'(mn_reg) * 15'(uc_reg);
        mmn_reg     <= cf_reg ? mm_reg : mn_reg;
        mvol_reg    <= 29'(mmmn_reg) * 29'(uvol_reg);
        kstride_reg <= 19'(mmn_reg) * 19'(uvol_reg);
    end

    // flow control
    logic      pipe_en;
    logic      accept;
    logic      skid_vld_reg;
    logic      out_vld_reg;
    tlam_out_t skid_reg;
    tlam_out_t out_reg;

    assign pipe_en = !skid_vld_reg;
    assign s_ready = pipe_en && (settle_reg == 2'd0);
    assign accept  = s_valid && s_ready;

    // divider 1: flat index / plane, or address / block volume
    d1_pay_t     p1i, p1o;
    logic [29:0] d1_num, d1_quo;
    logic [28:0] d1_den, d1_rem;
    logic        d1_vld;

    always_comb begin
        p1i.opcode      = s_data.opcode;
        p1i.slice_in    = s_data.slice_in;
        p1i.row_in      = s_data.row_in;
        p1i.col_in      = s_data.col_in;
        p1i.grid_row_in = s_data.grid_row_in;
        p1i.grid_col_in = s_data.grid_col_in;
        d1_num = (s_data.opcode == OP_FLAT) ? s_data.flat_index : 30'(s_data.address_in);
        d1_den = (s_data.opcode == OP_INV) ? mvol_reg : 29'(plane_reg);
    end

    tlam_div #(.DW(30), .VW(29), .PW($bits(d1_pay_t))) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
        .in_valid(accept), .in_num(d1_num), .in_den(d1_den), .in_pay(p1i),
        .out_valid(d1_vld), .out_quo(d1_quo), .out_rem(d1_rem), .out_pay(p1o)
    );

    // divider 2: plane remainder / columns, or block offset / micro volume
    d2_pay_t     p2i, p2o;
    logic [23:0] d2_num, d2_quo;
    logic [10:0] d2_den, d2_rem;
    logic        d2_vld;

    always_comb begin
        p2i.opcode      = p1o.opcode;
        p2i.tq          = (p1o.opcode == OP_FWD) ? 30'(p1o.slice_in) : d1_quo;
        p2i.row_in      = p1o.row_in;
        p2i.col_in      = p1o.col_in;
        p2i.grid_row_in = p1o.grid_row_in;
        p2i.grid_col_in = p1o.grid_col_in;
        d2_num = (p1o.opcode == OP_INV) ? d1_rem[23:0] : 24'(d1_rem[19:0]);
        d2_den = (p1o.opcode == OP_INV) ? 11'(uvol_reg) : tc_reg;
    end

    tlam_div #(.DW(24), .VW(11), .PW($bits(d2_pay_t))) u_div2 (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
        .in_valid(d1_vld), .in_num(d2_num), .in_den(d2_den), .in_pay(p2i),
        .out_valid(d2_vld), .out_quo(d2_quo), .out_rem(d2_rem), .out_pay(p2o)
    );

    // dividers 3 and 4: micro-block split, or macro index / micro offset split
    d3_pay_t     p3i, p3o;
    logic [9:0]  p4i, p4o;
    logic [9:0]  crow, ccol;
    logic        fwd_op;
    logic [19:0] d3_num, d3_quo, d4_num, d4_quo;
    logic [10:0] d3_den, d3_rem;
    logic [4:0]  d4_rem;
    logic        d3_vld, d4_vld;

    always_comb begin
        crow   = (p2o.opcode == OP_FLAT) ? d2_quo[9:0] : p2o.row_in;
        ccol   = (p2o.opcode == OP_FLAT) ? d2_rem[9:0] : p2o.col_in;
        fwd_op = (p2o.opcode == OP_FWD) || (p2o.opcode == OP_FLAT);
        p3i.opcode      = p2o.opcode;
        p3i.err         = fwd_op && ((p2o.tq >= 30'(ts_reg)) || (11'(crow) >= tr_reg) ||
                                     (11'(ccol) >= tc_reg));
        p3i.tq          = p2o.tq[23:0];
        p3i.grid_row_in = p2o.grid_row_in;
        p4i             = p2o.grid_col_in;
        d3_num = (p2o.opcode == OP_INV) ? d2_quo[19:0] : 20'(crow);
        d3_den = (p2o.opcode == OP_INV) ? mmn_reg : 11'(ur_reg);
        d4_num = (p2o.opcode == OP_INV) ? 20'(d2_rem[7:0]) : 20'(ccol);
    end

    tlam_div #(.DW(20), .VW(11), .PW($bits(d3_pay_t))) u_div3 (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
        .in_valid(d2_vld), .in_num(d3_num), .in_den(d3_den), .in_pay(p3i),
        .out_valid(d3_vld), .out_quo(d3_quo), .out_rem(d3_rem), .out_pay(p3o)
    );

    tlam_div #(.DW(20), .VW(5), .PW(10)) u_div4 (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
        .in_valid(d2_vld), .in_num(d4_num), .in_den(uc_reg), .in_pay(p4i),
        .out_valid(d4_vld), .out_quo(d4_quo), .out_rem(d4_rem), .out_pay(p4o)
    );

    // dividers 5 and 6: micro-block index -> grid position and macro offset
    d5_pay_t     p5i, p5o;
    logic [3:0]  p6i, p6o;
    logic [9:0]  d5_quo, d6_quo;
    logic [10:0] d5_rem, d6_rem;
    logic        d5_vld, d6_vld;
    logic        d34_vld;

    always_comb begin
        p5i.opcode      = p3o.opcode;
        p5i.err         = p3o.err;
        p5i.tq          = p3o.tq;
        p5i.grid_row_in = p3o.grid_row_in;
        p5i.grid_col_in = p4o;
        p5i.wq          = d3_quo[9:0];
        p5i.wr          = d3_rem[9:0];
        p5i.uq          = d4_quo[7:0];
        p6i             = d4_rem[3:0];
        d34_vld         = d3_vld && d4_vld;
    end

    tlam_div #(.DW(10), .VW(11), .PW($bits(d5_pay_t))) u_div5 (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
        .in_valid(d34_vld), .in_num(d3_quo[9:0]), .in_den(mm_reg), .in_pay(p5i),
        .out_valid(d5_vld), .out_quo(d5_quo), .out_rem(d5_rem), .out_pay(p5o)
    );

    tlam_div #(.DW(10), .VW(11), .PW(4)) u_div6 (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
        .in_valid(d34_vld), .in_num(d4_quo[9:0]), .in_den(mn_reg), .in_pay(p6i),
        .out_valid(d6_vld), .out_quo(d6_quo), .out_rem(d6_rem), .out_pay(p6o)
    );

    // E1: products
    e1_t         e1_next, e1_reg;
    logic        e1_vld_reg;
    logic [9:0]  fa, fb, inv_m, inv_n;
    logic [28:0] fp1_full;
    logic [24:0] ip1_full, ip3_full;

    always_comb begin
        fa    = cf_reg ? d6_rem[9:0] : d5_rem[9:0];
        fb    = cf_reg ? d5_rem[9:0] : d6_rem[9:0];
        inv_m = cf_reg ? p5o.wr : p5o.wq;
        inv_n = cf_reg ? p5o.wq : p5o.wr;
        fp1_full = 29'(fa) * 29'(kstride_reg);
        ip1_full = 25'(p5o.grid_row_in) * 25'(mmur_reg);
        ip3_full = 25'(p5o.grid_col_in) * 25'(mnuc_reg);
        e1_next.opcode = p5o.opcode;
        e1_next.err    = p5o.err;
        e1_next.gr     = d5_quo;
        e1_next.gc     = d6_quo;
        e1_next.tq     = p5o.tq;
        e1_next.fp1    = fp1_full[23:0];
        e1_next.fp2    = p5o.tq * mvol_reg[23:0];
        e1_next.fp3    = 19'(fb) * 19'(uvol_reg);
        e1_next.fp4    = 10'(p5o.wr[3:0]) * 10'(uc_reg) + 10'(p6o);
        e1_next.ip1    = ip1_full[19:0];
        e1_next.ip2    = 16'(inv_m) * 16'(ur_reg) + 16'(p5o.uq);
        e1_next.ip3    = ip3_full[19:0];
        e1_next.ip4    = 16'(inv_n) * 16'(uc_reg) + 16'(p6o);
    end

    // E2: partial sums
    e2_t  e2_next, e2_reg;
    logic e2_vld_reg;

    always_comb begin
        e2_next.opcode = e1_reg.opcode;
        e2_next.err    = e1_reg.err;
        e2_next.gr     = e1_reg.gr;
        e2_next.gc     = e1_reg.gc;
        e2_next.tq     = e1_reg.tq;
        e2_next.lin_a  = e1_reg.fp1 + e1_reg.fp2;
        e2_next.lin_b  = 20'(e1_reg.fp3) + 20'(e1_reg.fp4);
        e2_next.row    = e1_reg.ip1 + 20'(e1_reg.ip2);
        e2_next.col    = e1_reg.ip3 + 20'(e1_reg.ip4);
    end

    // E3: final address and result select
    tlam_out_t   e3_next, e3_reg;
    logic        e3_vld_reg;
    logic [23:0] lin;

    always_comb begin
        lin     = e2_reg.lin_a + 24'(e2_reg.lin_b);
        e3_next = '0;
        case (e2_reg.opcode) inside
            OP_FWD, OP_FLAT: begin
                if (e2_reg.err) begin
                    e3_next.range_error = 1'b1;
                end else begin
                    e3_next.grid_row_out = e2_reg.gr;
                    e3_next.grid_col_out = e2_reg.gc;
                    e3_next.address_out  = lin;
                end
            end
            OP_INV: begin
                e3_next.slice_out = e2_reg.tq;
                e3_next.row_out   = e2_reg.row;
                e3_next.col_out   = e2_reg.col;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            e1_vld_reg <= d5_vld && d6_vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
        end
    end

    // output register with skid entry
    logic push, pop;

    assign push = pipe_en && e3_vld_reg;
    assign pop  = out_vld_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (pop) begin
                out_reg      <= skid_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_reg     <= e3_reg;
                out_vld_reg <= 1'b1;
            end else begin
                skid_reg     <= e3_reg;
                skid_vld_reg <= 1'b1;
            end
        end else if (pop) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule
